// ===== hdl/per_client_sliding_window_limiter_core_defines.svh =====
// Assertion macros for the sliding-window limiter core.
// Depends on nothing; the including module supplies clk and rst.
`ifndef PER_CLIENT_SLIDING_WINDOW_LIMITER_CORE_DEFINES_SVH
`define PER_CLIENT_SLIDING_WINDOW_LIMITER_CORE_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define LSW_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define LSW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/lsw_pkg.sv =====
// Shared constants and types for the sliding-window limiter core.
// Used by lsw_cell and per_client_sliding_window_limiter_core.
package lsw_pkg;

  localparam int DEF_CLIENT_ENTRIES = 16;
  localparam int DEF_STAMP_SLOTS    = 8;
  localparam int DEF_TIME_BITS      = 32;

  localparam logic [3:0]  RST_MAX_REQUESTS   = 4'd5;
  localparam logic [15:0] RST_WINDOW_SECONDS = 16'd60;

  localparam logic [1:0] VERDICT_ALLOW  = 2'd0;
  localparam logic [1:0] VERDICT_LIMIT  = 2'd1;
  localparam logic [1:0] VERDICT_NOROOM = 2'd2;

  localparam logic [1:0] REG_MAX_REQUESTS   = 2'd0;
  localparam logic [1:0] REG_WINDOW_SECONDS = 2'd1;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic eval;
    logic commit;
  } lsw_ctl_t;

  // Candidate flags, also carried along the chain as "seen before here".
  typedef struct packed {
    logic match;
    logic free;
    logic allexp;
  } lsw_flag_t;

endpackage

// ===== hdl/lsw_cell.sv =====
// One client entry of the limiter: key, used bit and its timestamp slots.
// Depends on lsw_pkg; chained by per_client_sliding_window_limiter_core.
module lsw_cell #(
  parameter int STAMP_SLOTS = lsw_pkg::DEF_STAMP_SLOTS,
  parameter int TIME_BITS   = lsw_pkg::DEF_TIME_BITS,
  localparam int CW = $clog2(STAMP_SLOTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lsw_pkg::lsw_ctl_t     ctl,
  input  logic [31:0]           addr,
  input  logic [TIME_BITS-1:0]  now,
  input  logic [15:0]           window,
  input  logic [CW-1:0]         limit,
  input  logic                  any_match,
  input  logic                  any_free,
  input  lsw_pkg::lsw_flag_t    prior_in,
  output lsw_pkg::lsw_flag_t    prior_out,
  output logic                  sel,
  output logic                  allow,
  output logic [CW-1:0]         count
);

  logic                 used;
  logic [31:0]          key;
  logic [STAMP_SLOTS-1:0] live;
  logic [TIME_BITS-1:0] stamp [STAMP_SLOTS];
  logic [TIME_BITS-1:0] age [STAMP_SLOTS];
  logic [STAMP_SLOTS-1:0] expd;
  logic [STAMP_SLOTS-1:0] exp_q;
  lsw_pkg::lsw_flag_t   flags;
  logic [STAMP_SLOTS-1:0] live_eff;
  logic [STAMP_SLOTS-1:0] ins_mask;
  logic [CW-1:0]        held;

  // Age test of every slot against the window, modulo the time width.
  always_comb begin
    for (int s = 0; s < STAMP_SLOTS; s++) begin
      age[s]  = now - stamp[s];
      expd[s] = 64'(age[s]) > 64'(window);
    end
  end

  // Evaluate step: record the candidate flags and the expired slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (ctl.eval) begin
      flags.match  <= used && (key == addr);
      flags.free   <= !used;
      flags.allexp <= used && ((live & ~expd) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      exp_q <= expd;
    end
  end

  // Lowest candidate of the chosen kind wins along the chain.
  assign prior_out.match  = prior_in.match  | flags.match;
  assign prior_out.free   = prior_in.free   | flags.free;
  assign prior_out.allexp = prior_in.allexp | flags.allexp;

  always_comb begin
    if (any_match) begin
      sel = flags.match && !prior_in.match;
    end else if (any_free) begin
      sel = flags.free && !prior_in.free;
    end else begin
      sel = flags.allexp && !prior_in.allexp;
    end
  end

  // Surviving stamps, their count and the first empty slot.
  always_comb begin
    logic found;
    found    = 1'b0;
    live_eff = flags.match ? (live & ~exp_q) : '0;
    held     = '0;
    ins_mask = '0;
    for (int s = 0; s < STAMP_SLOTS; s++) begin
      held = held + CW'(live_eff[s]);
    end
    for (int s = 0; s < STAMP_SLOTS; s++) begin
      if (!live_eff[s] && !found) begin
        ins_mask[s] = 1'b1;
        found       = 1'b1;
      end
    end
  end

  assign allow = sel && (held < limit);
  assign count = sel ? (held + CW'(allow)) : '0;

  // Commit step: the selected cell takes the client, stamps if allowed.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      live <= '0;
    end else if (ctl.commit && sel) begin
      used <= 1'b1;
      live <= allow ? (live_eff | ins_mask) : live_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && sel) begin
      key <= addr;
      for (int s = 0; s < STAMP_SLOTS; s++) begin
        if (allow && ins_mask[s]) begin
          stamp[s] <= now;
        end
      end
    end
  end

endmodule

// ===== hdl/per_client_sliding_window_limiter_core.sv =====
// Top level of the per-client sliding-window rate limiter.
// Depends on lsw_pkg, lsw_cell and the assertion macro header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  request  | in_valid / in_ready  | client_addr, now_seconds
//  result   | out_valid / out_ready| verdict, recent_count
//  config   | cfg_write            | cfg_index, cfg_data
//
// A request is accepted, then evaluated in every cell, then picked along the
// cell chain and committed. The ripple through the client cells in the pick
// step sets the clock; the next request is taken in the cycle after commit.
// The pick cycle waits while the previous result has not been taken.
// Reset clears all used and live bits at once; no clearing pass is needed.
`include "per_client_sliding_window_limiter_core_defines.svh"

module per_client_sliding_window_limiter_core #(
  parameter int CLIENT_ENTRIES = lsw_pkg::DEF_CLIENT_ENTRIES,
  parameter int STAMP_SLOTS    = lsw_pkg::DEF_STAMP_SLOTS,
  parameter int TIME_BITS      = lsw_pkg::DEF_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] client_addr,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [3:0]  recent_count,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(STAMP_SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [3:0]           req_limit;
  logic [15:0]          window_seconds;
  logic [31:0]          addr_q;
  logic [TIME_BITS-1:0] now_q;
  logic [CW-1:0]        limit;
  logic                 go;
  lsw_pkg::lsw_ctl_t    ctl;
  lsw_pkg::lsw_flag_t   chain [CLIENT_ENTRIES+1];
  logic [CLIENT_ENTRIES-1:0] sel_vec;
  logic [CLIENT_ENTRIES-1:0] allow_vec;
  logic [CW-1:0]        cnt_vec [CLIENT_ENTRIES];
  logic [CW-1:0]        cnt_any;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_limit      <= lsw_pkg::RST_MAX_REQUESTS;
      window_seconds <= lsw_pkg::RST_WINDOW_SECONDS;
    end else if (cfg_write) begin
      case (cfg_index)
        lsw_pkg::REG_MAX_REQUESTS:   req_limit      <= cfg_data[3:0];
        lsw_pkg::REG_WINDOW_SECONDS: window_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective limit is capped at the slot count.
  assign limit = (32'(req_limit) > 32'(STAMP_SLOTS)) ? CW'(STAMP_SLOTS)
                                                     : CW'(req_limit);

  // Sequencer.
  assign in_ready   = (state == ST_IDLE);
  assign go         = !out_valid || out_ready;
  assign ctl.eval   = (state == ST_EVAL);
  assign ctl.commit = (state == ST_PICK) && go;

  always_comb begin
    case (state)
      ST_IDLE: state_next = in_valid ? ST_EVAL : ST_IDLE;
      ST_EVAL: state_next = ST_PICK;
      ST_PICK: state_next = go ? ST_IDLE : ST_PICK;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      addr_q <= client_addr;
      now_q  <= TIME_BITS'(now_seconds);
    end
  end

  // Row of client cells with the priority chain between neighbors.
  assign chain[0] = '0;

  for (genvar i = 0; i < CLIENT_ENTRIES; i++) begin : g_cell
    lsw_cell #(
      .STAMP_SLOTS (STAMP_SLOTS),
      .TIME_BITS   (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .addr      (addr_q),
      .now       (now_q),
      .window    (window_seconds),
      .limit     (limit),
      .any_match (chain[CLIENT_ENTRIES].match),
      .any_free  (chain[CLIENT_ENTRIES].free),
      .prior_in  (chain[i]),
      .prior_out (chain[i+1]),
      .sel       (sel_vec[i]),
      .allow     (allow_vec[i]),
      .count     (cnt_vec[i])
    );
  end

  // Only the selected cell drives a nonzero count.
  always_comb begin
    cnt_any = '0;
    for (int i = 0; i < CLIENT_ENTRIES; i++) begin
      cnt_any = cnt_any | cnt_vec[i];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (sel_vec == '0) begin
        verdict <= lsw_pkg::VERDICT_NOROOM;
      end else if (allow_vec != '0) begin
        verdict <= lsw_pkg::VERDICT_ALLOW;
      end else begin
        verdict <= lsw_pkg::VERDICT_LIMIT;
      end
      recent_count <= (32'(cnt_any) > 32'd15) ? 4'd15 : 4'(cnt_any);
    end
  end

  `LSW_ASSERT(a_one_cell, $onehot0(sel_vec), "more than one client cell selected")
  `LSW_ASSERT_IMPL(a_rose_pick, $rose(out_valid), $past(state) == ST_PICK, "result without pick step")
  `LSW_ASSERT_IMPL(a_noroom_zero, out_valid && verdict == lsw_pkg::VERDICT_NOROOM, recent_count == 4'd0, "no-room result with a count")
  `LSW_ASSERT_IMPL(a_accept_eval, in_valid && in_ready, ##1 state == ST_EVAL, "accepted transaction not evaluated")

endmodule

// ===== verif/per_client_sliding_window_limiter_core_tb.sv =====
// Self-checking testbench for the per-client sliding-window rate limiter core.
// Depends on lsw_pkg and the per_client_sliding_window_limiter_core RTL.
`timescale 1ns / 1ps

module per_client_sliding_window_limiter_core_tb;

  localparam int ENTRIES = lsw_pkg::DEF_CLIENT_ENTRIES;
  localparam int SLOTS = lsw_pkg::DEF_STAMP_SLOTS;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_STALL = 400;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [3:0] count;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] client_addr = '0;
  logic [31:0] now_seconds = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] verdict;
  logic [3:0] recent_count;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow copy of the limiter tables and registers.
  logic [31:0] shadow_key [ENTRIES];
  bit shadow_used [ENTRIES];
  logic [31:0] shadow_stamp [ENTRIES*SLOTS];
  bit shadow_live [ENTRIES*SLOTS];
  logic [3:0] shadow_max = lsw_pkg::RST_MAX_REQUESTS;
  logic [15:0] shadow_window = lsw_pkg::RST_WINDOW_SECONDS;

  request_t pending_requests[$];
  answer_t expected_answers[$];
  int fails = 0;
  bit quiet = 1'b0;
  bit sender_hold = 1'b0;
  int long_stall_requests = 0;
  logic [31:0] clock_now = 32'hFFFF_FF00;
  logic [31:0] client_pool [24];

  per_client_sliding_window_limiter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .client_addr(client_addr), .now_seconds(now_seconds),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .recent_count(recent_count),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic bit stamp_stale(input logic [31:0] now, input logic [31:0] t);
    logic [31:0] age;
    age = now - t;
    return age > {16'd0, shadow_window};
  endfunction

  // Looks up or claims a client entry, ages its stamps, records an allowed request.
  function automatic answer_t rate_decision(input request_t r);
    answer_t a;
    int hit, limit, count, k;
    bit busy;
    hit = -1;
    count = 0;
    limit = (shadow_max > SLOTS) ? SLOTS : shadow_max;
    for (int e = 0; e < ENTRIES; e++)
      if (hit < 0 && shadow_used[e] && shadow_key[e] == r.addr) hit = e;
    if (hit < 0) begin
      for (int e = 0; e < ENTRIES; e++)
        if (hit < 0 && !shadow_used[e]) hit = e;
      for (int e = 0; e < ENTRIES; e++) begin
        busy = 1'b0;
        for (int s = 0; s < SLOTS; s++)
          if (shadow_live[e*SLOTS+s] && !stamp_stale(r.now, shadow_stamp[e*SLOTS+s]))
            busy = 1'b1;
        if (hit < 0 && !busy) hit = e;
      end
      if (hit < 0) begin
        a.verdict = lsw_pkg::VERDICT_NOROOM;
        a.count = 4'd0;
        return a;
      end
      shadow_used[hit] = 1'b1;
      shadow_key[hit] = r.addr;
      for (int s = 0; s < SLOTS; s++) shadow_live[hit*SLOTS+s] = 1'b0;
    end
    for (int s = 0; s < SLOTS; s++) begin
      k = hit*SLOTS + s;
      if (shadow_live[k]) begin
        if (stamp_stale(r.now, shadow_stamp[k])) shadow_live[k] = 1'b0;
        else count++;
      end
    end
    if (count >= limit) begin
      a.verdict = lsw_pkg::VERDICT_LIMIT;
    end else begin
      a.verdict = lsw_pkg::VERDICT_ALLOW;
      for (int s = 0; s < SLOTS; s++) begin
        k = hit*SLOTS + s;
        if (a.verdict == lsw_pkg::VERDICT_ALLOW && !shadow_live[k] && count >= 0) begin
          shadow_live[k] = 1'b1;
          shadow_stamp[k] = r.now;
          count++;
          count = -count;
        end
      end
      if (count < 0) count = -count;
    end
    a.count = (count > 15) ? 4'd15 : count[3:0];
    return a;
  endfunction

  // Driver: offers queued requests with random gaps and predicts on acceptance.
  int send_gap = 0;
  always @(posedge clk) begin
    request_t r;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_answers.insert(expected_answers.size(),
                                rate_decision('{client_addr, now_seconds}));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0 && !sender_hold) begin
          r = pending_requests.pop_front();
          in_valid <= 1'b1;
          client_addr <= r.addr;
          now_seconds <= r.now;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and throttles out_ready.
  int stall_left = 0;
  int long_stalls_done = 0;
  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result: verdict %0d recent_count %0d", verdict, recent_count);
          fails++;
        end else begin
          want = expected_answers.pop_front();
          if (verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
            fails++;
          end
          if (recent_count !== want.count) begin
            $error("recent_count: expected %0d, actual %0d", want.count, recent_count);
            fails++;
          end
        end
      end
      if (long_stalls_done < long_stall_requests) begin
        long_stalls_done++;
        stall_left = LONG_STALL;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("per_client_sliding_window_limiter_core: mismatch");
      $finish;
    end
  end

  task automatic add_request(input logic [31:0] addr, input logic [31:0] now);
    pending_requests.insert(pending_requests.size(), '{addr, now});
  endtask

  task automatic wait_idle();
    while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == lsw_pkg::REG_MAX_REQUESTS) shadow_max = value[3:0];
    else if (idx == lsw_pkg::REG_WINDOW_SECONDS) shadow_window = value;
  endtask

  // Mostly repeat clients from a pool, with time moving on at a pace tied to the window.
  task automatic random_requests(input int n);
    logic [31:0] addr;
    int span;
    span = (shadow_window / 4) + 2;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) addr = client_pool[$urandom_range(0, 23)];
      else addr = $urandom;
      case ($urandom_range(0, 19))
        0: clock_now = clock_now + shadow_window + $urandom_range(1, 3);
        1: clock_now = $urandom;
        default: clock_now = clock_now + $urandom_range(0, span);
      endcase
      add_request(addr, clock_now);
    end
  endtask

  initial begin
    for (int e = 0; e < ENTRIES; e++) shadow_used[e] = 1'b0;
    for (int k = 0; k < ENTRIES*SLOTS; k++) shadow_live[k] = 1'b0;
    for (int i = 0; i < 24; i++) client_pool[i] = $urandom;
    client_pool[0] = 32'h0000_0000;
    client_pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: one client up to the limit, expiry across the time wrap, extreme fields.
    for (int i = 0; i < 6; i++) add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(32'h0000_0000, 32'h0000_0000);
    add_request(32'hFFFF_FFFF, 32'd60);
    add_request(32'hFFFF_FFFF, 32'd61);
    // Fill the table with fresh clients, then one more finds no room.
    for (int i = 0; i < 15; i++) add_request(32'hA000_0000 + i, 32'd61);
    add_request(32'h5555_AAAA, 32'd62);
    // Once everything has expired a new client reuses an entry.
    add_request(32'hAAAA_5555, 32'd200);
    wait_idle();

    // Registers beyond index 1 must be ignored.
    write_reg(2'd2, 16'hFFFF);
    write_reg(2'd3, 16'h0000);
    clock_now = 32'd300;
    random_requests(120);
    wait_idle();

    // Zero limit refuses everything.
    write_reg(lsw_pkg::REG_MAX_REQUESTS, 16'd0);
    random_requests(40);
    wait_idle();

    // Limit above the slot count, largest window; receiver holds off for a long stretch.
    write_reg(lsw_pkg::REG_MAX_REQUESTS, 16'd15);
    write_reg(lsw_pkg::REG_WINDOW_SECONDS, 16'hFFFF);
    long_stall_requests++;
    random_requests(200);
    wait_idle();

    // Zero window: anything older than the current second expires.
    write_reg(lsw_pkg::REG_WINDOW_SECONDS, 16'd0);
    write_reg(lsw_pkg::REG_MAX_REQUESTS, 16'd1);
    random_requests(150);
    wait_idle();

    write_reg(lsw_pkg::REG_MAX_REQUESTS, 16'd8);
    write_reg(lsw_pkg::REG_WINDOW_SECONDS, 16'd20);
    random_requests(150);
    // Sender pauses until every outstanding result has come back.
    sender_hold = 1'b1;
    while (expected_answers.size() > 0) @(posedge clk);
    sender_hold = 1'b0;
    random_requests(150);
    wait_idle();

    write_reg(lsw_pkg::REG_MAX_REQUESTS, 16'd3);
    write_reg(lsw_pkg::REG_WINDOW_SECONDS, 16'd1);
    random_requests(120);
    wait_idle();

    // Last stretch at full rate on both sides.
    quiet = 1'b1;
    write_reg(lsw_pkg::REG_MAX_REQUESTS, 16'd5);
    write_reg(lsw_pkg::REG_WINDOW_SECONDS, 16'd60);
    random_requests(150);
    wait_idle();
    repeat (20) @(posedge clk);

    if (fails == 0) begin
      $display("per_client_sliding_window_limiter_core: match");
    end else begin
      $display("per_client_sliding_window_limiter_core: mismatch");
    end
    $finish;
  end

endmodule
